### hdl/pcsp_pkg.sv
// Shared types and defaults for the parent/child subsplit to PCSP block.
package pcsp_pkg;

   localparam int unsigned TAXA_DEFAULT = 16;
   localparam int unsigned SUBSPLIT_W   = 32;
   localparam int unsigned PCSP_W       = 48;

   typedef struct packed {
      logic [SUBSPLIT_W-1:0] parent_split;
      logic [SUBSPLIT_W-1:0] child_split;
   } req_type;

   typedef struct packed {
      logic [PCSP_W-1:0] pcsp_bits;
      logic              pair_valid;
      logic              child_side;
   } rsp_type;

endpackage

### hdl/pcsp_from_parent_child.sv
// Top level: parent/child subsplit pair in, three-clade PCSP with flags out.
// An accepted request beat goes through the input register and then the
// response register. Throughput: one pair per cycle while rsp_stall is low;
// each register advances whenever the next stage is free or moving on.
// Reset: synchronous, active high; clears both valid flags, no data cleared.
module pcsp_from_parent_child import pcsp_pkg::*; #(
   parameter int unsigned TAXA = TAXA_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    hold_valid;
   req_type hold_data;
   logic    hold_take;
   rsp_type result;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;

   pcsp_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .hold_valid (hold_valid),
      .hold_data  (hold_data),
      .hold_take  (hold_take)
   );

   pcsp_check #(
      .TAXA (TAXA)
   ) u_check (
      .pair   (hold_data),
      .result (result)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign hold_take    = out_free;
   assign rsp_valid_in = out_free ? hold_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free && hold_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted beat always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> hold_valid)
      else $error("accepted request beat not held in input register");

   // A held pair moves to the response register when that register is free.
   assert property (@(posedge clock) disable iff (reset)
      (hold_valid && out_free) |=> rsp_valid)
      else $error("held pair did not reach the response register");

   // A rejected pair carries no PCSP and no side.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.pair_valid) |->
         (rsp_data.pcsp_bits == '0 && !rsp_data.child_side))
      else $error("invalid pair response carries nonzero payload");

endmodule

### hdl/pcsp_req_stage.sv
// Input register stage that captures one subsplit pair beat.
module pcsp_req_stage import pcsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    hold_valid,
   output req_type hold_data,
   input  logic    hold_take
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   // The stage can refill in the cycle its contents move on.
   assign req_stall = valid_ff && !hold_take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !hold_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

### hdl/pcsp_check.sv
// Clade checks and PCSP assembly for one registered subsplit pair.
module pcsp_check import pcsp_pkg::*; #(
   parameter int unsigned TAXA = TAXA_DEFAULT
) (
   input  req_type pair,
   output rsp_type result
);

   localparam int unsigned SW = 2 * TAXA;

   logic [63:0]     par_ext;
   logic [63:0]     chi_ext;
   logic [SW-1:0]   par;
   logic [SW-1:0]   chi;
   logic [TAXA-1:0] p_left;
   logic [TAXA-1:0] p_right;
   logic [TAXA-1:0] c_left;
   logic [TAXA-1:0] c_right;
   logic [TAXA-1:0] c_union;
   logic [TAXA-1:0] sister;
   logic [TAXA-1:0] focal;
   logic            distinct;
   logic            of_left;
   logic            of_right;
   logic            ok;
   logic [63:0]     pcsp_ext;

   // Bits at and above twice the clade width take no part.
   assign par_ext = 64'(pair.parent_split);
   assign chi_ext = 64'(pair.child_split);
   assign par     = par_ext[SW-1:0];
   assign chi     = chi_ext[SW-1:0];

   assign p_left  = par[SW-1:TAXA];
   assign p_right = par[TAXA-1:0];
   assign c_left  = chi[SW-1:TAXA];
   assign c_right = chi[TAXA-1:0];
   assign c_union = c_left | c_right;

   assign distinct = (par != chi);
   assign of_left  = distinct && (c_union == p_left);
   assign of_right = distinct && (c_union == p_right);
   assign ok       = ((p_left & p_right) == '0) && ((c_left & c_right) == '0)
                     && (of_left || of_right);

   // A child of the left clade puts the right clade on top as the sister.
   assign sister   = of_left ? p_right : p_left;
   assign focal    = of_left ? p_left : p_right;
   assign pcsp_ext = 64'({sister, focal, c_right});

   always_comb begin
      result.pcsp_bits  = ok ? pcsp_ext[PCSP_W-1:0] : '0;
      result.pair_valid = ok;
      result.child_side = ok && !of_left;
   end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the parent/child subsplit to PCSP block.
`timescale 1ns / 1ps

module tb_top;
   import pcsp_pkg::*;

   localparam int unsigned CW           = TAXA_DEFAULT;
   localparam int unsigned RANDOM_PAIRS = 1950;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DIRECTED_N   = 16;
   localparam logic        SIDE_LEFT    = 1'b0;
   localparam logic        SIDE_RIGHT   = 1'b1;

   typedef enum int unsigned {
      PAIR_WELL_FORMED,
      PAIR_BROKEN,
      PAIR_NOISE
   } pair_kind_type;

   // Predicts the PCSP for each accepted pair and checks responses in order.
   class pcsp_scoreboard;
      rsp_type     expected_q[$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      function rsp_type predict_pcsp(req_type r);
         logic [2*CW-1:0] par;
         logic [2*CW-1:0] chi;
         logic [CW-1:0]   p_left;
         logic [CW-1:0]   p_right;
         logic [CW-1:0]   c_right;
         logic [CW-1:0]   c_union;
         logic            distinct;
         logic            of_left;
         logic            of_right;
         rsp_type         res;
         par      = r.parent_split[2*CW-1:0];
         chi      = r.child_split[2*CW-1:0];
         p_left   = par[2*CW-1:CW];
         p_right  = par[CW-1:0];
         c_right  = chi[CW-1:0];
         c_union  = chi[2*CW-1:CW] | c_right;
         distinct = (par != chi);
         of_left  = distinct && (c_union == p_left);
         of_right = distinct && (c_union == p_right);
         res      = '0;
         if (((p_left & p_right) == '0) && ((chi[2*CW-1:CW] & c_right) == '0)
             && (of_left || of_right)) begin
            res.pair_valid = 1'b1;
            // A child of the left clade puts the right clade on top as sister.
            if (of_left) begin
               res.pcsp_bits  = {p_right, p_left, c_right};
               res.child_side = SIDE_LEFT;
            end else begin
               res.pcsp_bits  = {p_left, p_right, c_right};
               res.child_side = SIDE_RIGHT;
            end
         end
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.insert(expected_q.size(), predict_pcsp(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing expected: %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.pcsp_bits !== want.pcsp_bits) begin
            $error("pcsp_bits: expected %h, got %h", want.pcsp_bits, got.pcsp_bits);
            errors++;
         end
         if (got.pair_valid !== want.pair_valid) begin
            $error("pair_valid: expected %b, got %b", want.pair_valid, got.pair_valid);
            errors++;
         end
         if (got.child_side !== want.child_side) begin
            $error("child_side: expected %b, got %b", want.child_side, got.child_side);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   pcsp_scoreboard scoreboard = new();
   int unsigned    cycle_count = 0;
   int unsigned    holds_asked = 0;
   int unsigned    holds_served = 0;

   pcsp_from_parent_child uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_response(rsp_data);
      end
   end

   // Response side: stall modes change every so often, and a long hold-off
   // is served whenever the stimulus asks for one.
   initial begin
      int unsigned stall_mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned phase;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      phase      = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               3: rsp_stall <= ((phase % 5) < 2);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   function automatic req_type make_pair();
      logic [CW-1:0] p_left;
      logic [CW-1:0] p_right;
      logic [CW-1:0] focal;
      logic [CW-1:0] c_left;
      logic [CW-1:0] c_right;
      logic          sparse;
      logic          lopsided;
      logic          whole_side;
      int unsigned   pick;
      int unsigned   role;
      pair_kind_type kind;
      req_type       r;
      pick = $urandom_range(0, 9);
      kind = (pick < 7) ? PAIR_WELL_FORMED : (pick < 9) ? PAIR_BROKEN : PAIR_NOISE;
      if (kind == PAIR_NOISE) begin
         r.parent_split = $urandom;
         r.child_split  = $urandom;
         return r;
      end
      p_left     = '0;
      p_right    = '0;
      c_left     = '0;
      c_right    = '0;
      sparse     = ($urandom_range(0, 3) == 0);
      lopsided   = ($urandom_range(0, 7) == 0);
      whole_side = 1'($urandom_range(0, 1));
      for (int t = 0; t < CW; t++) begin
         role = $urandom_range(0, sparse ? 5 : 2);
         if (role == 0) begin
            p_left[t] = 1'b1;
         end else if (role == 1) begin
            p_right[t] = 1'b1;
         end
      end
      focal = $urandom_range(0, 1) ? p_right : p_left;
      for (int t = 0; t < CW; t++) begin
         if (focal[t]) begin
            if (lopsided ? whole_side : 1'($urandom_range(0, 1))) begin
               c_left[t] = 1'b1;
            end else begin
               c_right[t] = 1'b1;
            end
         end
      end
      r.parent_split = {p_left, p_right};
      r.child_split  = {c_left, c_right};
      if (kind == PAIR_BROKEN) begin
         case ($urandom_range(0, 2))
            0: r.parent_split[$urandom_range(0, 2*CW-1)] ^= 1'b1;
            1: r.child_split[$urandom_range(0, 2*CW-1)] ^= 1'b1;
            default: r.child_split = r.parent_split;
         endcase
      end
      return r;
   endfunction

   // Offers one pair from a falling edge and returns at the falling edge after
   // the beat, leaving valid high for the caller to keep or drop.
   task automatic send_pair(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      scoreboard.note_request(r);
      @(negedge clock);
   endtask

   task automatic idle_request(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   initial begin
      req_type     directed_pairs [DIRECTED_N];
      int unsigned burst_left;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_pairs[0]  = {32'h0000_0000, 32'h0000_0000};  // child equals parent
      directed_pairs[1]  = {32'hFFFF_FFFF, 32'hFFFF_FFFF};
      directed_pairs[2]  = {32'hFFFF_0000, 32'hFF00_00FF};  // child of left clade
      directed_pairs[3]  = {32'h0F0F_F0F0, 32'hF000_00F0};  // child of right clade
      directed_pairs[4]  = {32'h8000_0001, 32'h0000_0001};
      directed_pairs[5]  = {32'hFFFF_0000, 32'hFFFF_0000};  // child equals parent
      directed_pairs[6]  = {32'hAAAA_0000, 32'h0000_0000};  // empty right clade
      directed_pairs[7]  = {32'h00FF_0180, 32'h00F0_000F};  // parent clades overlap
      directed_pairs[8]  = {32'h00FF_FF00, 32'h00F1_000F};  // child clades overlap
      directed_pairs[9]  = {32'h0001_FFFE, 32'h8000_7FFE};
      directed_pairs[10] = {32'hFFFE_0001, 32'h0000_FFFE};
      directed_pairs[11] = {32'h8000_0001, 32'h8000_0000};
      directed_pairs[12] = {32'hF000_0F00, 32'hE000_0100};  // union matches neither
      directed_pairs[13] = {32'h0000_FFFF, 32'hFFFF_0000};
      directed_pairs[14] = {32'h7FFF_8000, 32'h5555_2AAA};
      directed_pairs[15] = {32'h1234_4321, 32'h0234_1000};
      foreach (directed_pairs[i]) begin
         if ($urandom_range(0, 2) == 0) begin
            idle_request($urandom_range(1, 3));
         end
         send_pair(directed_pairs[i]);
      end

      burst_left = 0;
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == 600) begin
            // Long receiver hold-off while pairs keep coming, to fill the pipe.
            holds_asked++;
         end
         if (i == 1300) begin
            req_valid <= 1'b0;
            while (scoreboard.pending() != 0) @(negedge clock);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
               idle_request($urandom_range(1, 6));
            end
         end
         burst_left--;
         send_pair(make_pair());
      end

      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (scoreboard.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
